@@ rtl/core/frame_paced_console_io_device_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the frame paced console core
// Concurrent checks, clocked on clk and held off while arst_n is low.
// They expand to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FRAME_PACED_CONSOLE_IO_DEVICE_CORE_DEFINES_SVH
`define FRAME_PACED_CONSOLE_IO_DEVICE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define FPCIO_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fpcio: same-cycle check failed");
// Next-cycle implication.
`define FPCIO_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fpcio: next-cycle check failed");
`else
`define FPCIO_ASSERT_IMP(label, ante, cons)
`define FPCIO_ASSERT_NXT(label, ante, cons)
`endif
`endif

@@ rtl/core/fpcio_pkg.sv @@
// ----------------------------------------------------------------------------
// fpcio_pkg
// Constants, command codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package fpcio_pkg;

	localparam int KEY_DEPTH   = 8;
	localparam int VIDEO_BYTES = 40;
	localparam int KA_W        = $clog2(KEY_DEPTH);
	localparam int VA_W        = (VIDEO_BYTES > 1) ? $clog2(VIDEO_BYTES) : 1;

	localparam int CLK_W     = 48;
	localparam int IV_W      = 12;
	localparam int WAIT_W    = 13;
	localparam int DIV_STEPS = CLK_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam logic [2:0] CMD_READ  = 3'd0;
	localparam logic [2:0] CMD_WRITE = 3'd1;
	localparam logic [2:0] CMD_KEY   = 3'd2;
	localparam logic [2:0] CMD_POLL  = 3'd3;
	localparam logic [2:0] CMD_TICK  = 3'd4;

	localparam logic [7:0] OFF_RATE  = 8'd17;
	localparam logic [7:0] OFF_DRAW  = 8'd18;
	localparam logic [7:0] OFF_KEYS  = 8'd24;
	localparam logic [7:0] OFF_VIDEO = 8'd40;

	localparam int SLACK_MS   = 10;
	localparam int GUARD_MS   = 5;
	localparam int WAIT_MAX   = 4000;
	localparam int RATE_NUM   = 4000;
	localparam int RESET_RATE = 40;
	localparam int RESET_IV   = 100;
	localparam logic [7:0] SPACE = 8'h20;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV
	} state_t;

	typedef struct packed {
		logic capture;
		logic apply;
		logic div_start;
		logic fin;
	} ctl_t;

	typedef struct packed {
		logic need_div;
		logic div_busy;
	} sts_t;

endpackage

@@ rtl/core/fpcio_div.sv @@
// ----------------------------------------------------------------------------
// fpcio_div
// Restoring divider, one quotient bit per cycle, shared by the rate divide
// and the deadline catch-up.
// ----------------------------------------------------------------------------
module fpcio_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [fpcio_pkg::CLK_W-1:0] dividend,
	input  logic [fpcio_pkg::IV_W-1:0]  divisor,
	output logic                        busy,
	output logic [fpcio_pkg::CLK_W-1:0] quotient,
	output logic [fpcio_pkg::IV_W-1:0]  remainder
);
	import fpcio_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [CLK_W-1:0] dq_q;
	logic [IV_W-1:0]  rem_q;
	logic [IV_W-1:0]  dsr_q;
	logic [IV_W:0]    shifted;
	logic [IV_W:0]    diff;
	logic             ge;

	always_comb begin
		shifted = {rem_q, dq_q[CLK_W-1]};
		ge      = shifted >= {1'b0, dsr_q};
		diff    = shifted - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[CLK_W-2:0], ge};
			rem_q <= ge ? diff[IV_W-1:0] : shifted[IV_W-1:0];
		end
	end

	assign busy      = busy_q;
	assign quotient  = dq_q;
	assign remainder = rem_q;

endmodule

@@ rtl/core/fpcio_ctrl.sv @@
// ----------------------------------------------------------------------------
// fpcio_ctrl
// Transaction sequencer: accept, execute, optional divide, result hand-off.
// ----------------------------------------------------------------------------
module fpcio_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output fpcio_pkg::ctl_t   ctl,
	input  fpcio_pkg::sts_t   sts
);
	import fpcio_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= load || (out_valid_q && out_stall);
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		out_free = !out_valid_q || !out_stall;
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctl.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.need_div) begin
					ctl.div_start = 1'b1;
					state_d       = ST_DIV;
				end else if (out_free) begin
					ctl.apply = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (!sts.div_busy && out_free) begin
					ctl.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		load = ctl.apply || ctl.fin;
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/core/fpcio_dpath.sv @@
// ----------------------------------------------------------------------------
// fpcio_dpath
// Register file, key queue, video memory, frame pacing and result register.
// ----------------------------------------------------------------------------
module fpcio_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fpcio_pkg::ctl_t                     ctl,
	output fpcio_pkg::sts_t                     sts,
	input  logic [2:0]                          cmd,
	input  logic [7:0]                          address,
	input  logic [7:0]                          write_data,
	input  logic [7:0]                          key_code,
	output logic [7:0]                          read_data,
	output logic signed [fpcio_pkg::WAIT_W-1:0] wait_ms,
	output logic                                frame_waiting
);
	import fpcio_pkg::*;

	// Captured transaction
	logic [2:0] cmd_q;
	logic [7:0] addr_q;
	logic [7:0] wdata_q;
	logic [7:0] keyc_q;

	// Architectural state
	logic [7:0]             key_q [KEY_DEPTH];
	logic [7:0]             vid_mem [VIDEO_BYTES];
	logic [VIDEO_BYTES-1:0] vid_ok_q;
	logic [7:0]             rate_q;
	logic [IV_W-1:0]        iv_q;
	logic [CLK_W-1:0]       nft_q;
	logic [CLK_W-1:0]       ms_q;
	logic                   pend_q;

	// Registered video read
	logic [7:0] vid_rd_q;
	logic       vid_rd_ok_q;

	// Result register
	logic [7:0]              read_data_q;
	logic signed [WAIT_W-1:0] wait_q;
	logic                    fw_q;

	logic [8:0]      in_voff;
	logic [VA_W-1:0] in_vidx;
	logic [8:0]      addr9;
	logic [8:0]      koff;
	logic [8:0]      voff;
	logic [KA_W-1:0] kidx;
	logic [VA_W-1:0] vidx;
	logic            key_hit;
	logic            vid_hit;
	logic            vid_we;
	logic [7:0]      rd_val;

	logic [CLK_W:0]  ms_ext;
	logic [CLK_W:0]  nft_ext;
	logic [CLK_W:0]  nf_ext;
	logic [CLK_W:0]  gap;
	logic            due;
	logic            nf_lt;
	logic            iv_nz;
	logic            ahead;
	logic signed [WAIT_W-1:0] wait_run;
	logic            is_poll;
	logic            rate_nz_wr;

	logic [KEY_DEPTH-1:0] fill;
	logic                 seen;

	logic [CLK_W-1:0] div_dividend;
	logic [IV_W-1:0]  div_divisor;
	logic [CLK_W-1:0] div_quot;
	logic [IV_W-1:0]  div_rem;
	logic             div_busy;
	logic [IV_W-1:0]  adj;
	logic [CLK_W-1:0] nft_poll;
	logic [CLK_W-1:0] nft_rate;
	logic             pend_nx;

	fpcio_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (ctl.div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.busy      (div_busy),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	// Address decode
	always_comb begin
		in_voff = {1'b0, address} - {1'b0, OFF_VIDEO};
		in_vidx = in_voff[VA_W-1:0];
		addr9   = {1'b0, addr_q};
		koff    = addr9 - {1'b0, OFF_KEYS};
		voff    = addr9 - {1'b0, OFF_VIDEO};
		kidx    = koff[KA_W-1:0];
		vidx    = voff[VA_W-1:0];
		key_hit = (addr9 >= {1'b0, OFF_KEYS}) &&
			(addr9 < ({1'b0, OFF_KEYS} + 9'(KEY_DEPTH)));
		vid_hit = (addr9 >= {1'b0, OFF_VIDEO}) &&
			(addr9 < ({1'b0, OFF_VIDEO} + 9'(VIDEO_BYTES)));
		vid_we  = ctl.apply && (cmd_q == CMD_WRITE) && vid_hit;

		if (addr_q == OFF_RATE) begin
			rd_val = rate_q;
		end else if (key_hit) begin
			rd_val = key_q[kidx];
		end else if (vid_hit) begin
			rd_val = vid_rd_ok_q ? vid_rd_q : SPACE;
		end else begin
			rd_val = 8'd0;
		end
	end

	// Frame pacing arithmetic
	always_comb begin
		ms_ext  = {1'b0, ms_q};
		nft_ext = {1'b0, nft_q};
		iv_nz   = (iv_q != '0);
		due     = (nft_q != '0) && ((ms_ext + (CLK_W+1)'(SLACK_MS)) >= nft_ext);
		nf_ext  = nft_ext + (CLK_W+1)'(iv_q);
		nf_lt   = nf_ext < ms_ext;
		ahead   = nft_ext > (ms_ext + (CLK_W+1)'(GUARD_MS));
		gap     = nft_ext - ms_ext - (CLK_W+1)'(GUARD_MS);
		if (pend_q && (nft_q != '0)) begin
			if (!ahead) begin
				wait_run = '0;
			end else if (gap > (CLK_W+1)'(WAIT_MAX)) begin
				wait_run = WAIT_W'(WAIT_MAX);
			end else begin
				wait_run = $signed(gap[WAIT_W-1:0]);
			end
		end else begin
			wait_run = '1;
		end

		is_poll    = (cmd_q == CMD_POLL);
		rate_nz_wr = (cmd_q == CMD_WRITE) && (addr_q == OFF_RATE) && (wdata_q != 8'd0);
		sts.need_div = rate_nz_wr || (is_poll && due && iv_nz && nf_lt);
		sts.div_busy = div_busy;

		div_dividend = is_poll ? (ms_q - nf_ext[CLK_W-1:0]) : CLK_W'(RATE_NUM);
		div_divisor  = is_poll ? iv_q : IV_W'(wdata_q);

		// Land on the first deadline at or past the clock
		adj      = (div_rem == '0) ? '0 : (iv_q - div_rem);
		nft_poll = ms_q + CLK_W'(adj);
		nft_rate = ms_q + CLK_W'(div_quot[IV_W-1:0]);
	end

	// First empty key slot
	always_comb begin
		seen = 1'b0;
		for (int i = 0; i < KEY_DEPTH; i++) begin
			fill[i] = (key_q[i] == 8'd0) && !seen;
			if (key_q[i] == 8'd0) begin
				seen = 1'b1;
			end
		end
	end

	always_comb begin
		pend_nx = pend_q;
		if (ctl.apply && (cmd_q == CMD_WRITE) && (addr_q == OFF_DRAW) && iv_nz) begin
			pend_nx = 1'b1;
		end
		if (ctl.apply && is_poll && due) begin
			pend_nx = 1'b0;
		end
		if (ctl.fin && is_poll) begin
			pend_nx = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEY_DEPTH; i++) begin
				key_q[i] <= 8'd0;
			end
			vid_ok_q <= '0;
			rate_q   <= 8'(RESET_RATE);
			iv_q     <= IV_W'(RESET_IV);
			nft_q    <= CLK_W'(RESET_IV);
			ms_q     <= '0;
			pend_q   <= 1'b0;
		end else begin
			pend_q <= pend_nx;
			if (vid_we) begin
				vid_ok_q[vidx] <= 1'b1;
			end
			if (ctl.apply) begin
				case (cmd_q)
					CMD_WRITE: begin
						if (addr_q == OFF_RATE) begin
							rate_q <= 8'd0;
							iv_q   <= '0;
							nft_q  <= '0;
						end else if (addr_q == OFF_KEYS) begin
							for (int i = 0; i < KEY_DEPTH - 1; i++) begin
								key_q[i] <= key_q[i+1];
							end
							key_q[KEY_DEPTH-1] <= 8'd0;
						end
					end
					CMD_KEY: begin
						for (int i = 0; i < KEY_DEPTH; i++) begin
							if (fill[i]) begin
								key_q[i] <= keyc_q;
							end
						end
					end
					CMD_POLL: begin
						if (due && iv_nz) begin
							nft_q <= nf_ext[CLK_W-1:0];
						end
					end
					CMD_TICK: begin
						ms_q <= ms_q + CLK_W'(1);
					end
					default: begin
					end
				endcase
			end
			if (ctl.fin) begin
				if (is_poll) begin
					nft_q <= nft_poll;
				end else begin
					rate_q <= wdata_q;
					iv_q   <= div_quot[IV_W-1:0];
					nft_q  <= nft_rate;
				end
			end
		end
	end

	// Video memory and captured transaction
	always_ff @(posedge clk) begin
		if (vid_we) begin
			vid_mem[vidx] <= wdata_q;
		end
		if (ctl.capture) begin
			vid_rd_q    <= vid_mem[in_vidx];
			vid_rd_ok_q <= vid_ok_q[in_vidx];
			cmd_q       <= cmd;
			addr_q      <= address;
			wdata_q     <= write_data;
			keyc_q      <= key_code;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (ctl.apply || ctl.fin) begin
			read_data_q <= (ctl.apply && (cmd_q == CMD_READ)) ? rd_val : 8'd0;
			fw_q        <= pend_nx;
			if (ctl.apply && is_poll) begin
				wait_q <= due ? '0 : wait_run;
			end else if (ctl.fin && is_poll) begin
				wait_q <= '0;
			end else begin
				wait_q <= '1;
			end
		end
	end

	assign read_data     = read_data_q;
	assign wait_ms       = wait_q;
	assign frame_waiting = fw_q;

endmodule

@@ rtl/core/frame_paced_console_io_device_core.sv @@
// ----------------------------------------------------------------------------
// frame_paced_console_io_device_core
// Console peripheral: bus registers, key queue, video memory, frame pacing.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake              Fields
//  in       in   in_valid / in_stall    cmd, address, write_data, key_code
//  out      out  out_valid / out_stall  read_data, wait_ms, frame_waiting
//
//  Plain reads, writes, key presses, ticks and polls go through accept, then
//  execute into the result register.
//  A non-zero frame-rate write or a poll that skips missed frames also runs
//  the 48-step restoring divider before its result is loaded.
//  Reset clears all state at once; per-entry valid bits read video as spaces.
//  A stalled result holds its register; the next waits in execute or divide.
// ----------------------------------------------------------------------------
`include "frame_paced_console_io_device_core_defines.svh"

module frame_paced_console_io_device_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// Command channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [2:0]                          cmd,
	input  logic [7:0]                          address,
	input  logic [7:0]                          write_data,
	input  logic [7:0]                          key_code,
	// Result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [7:0]                          read_data,
	output logic signed [fpcio_pkg::WAIT_W-1:0] wait_ms,
	output logic                                frame_waiting
);
	import fpcio_pkg::*;

	ctl_t ctl;
	sts_t sts;

	// Sequence each transaction
	fpcio_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctl       (ctl),
		.sts       (sts)
	);

	// Hold the device state and build the result
	fpcio_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.sts           (sts),
		.cmd           (cmd),
		.address       (address),
		.write_data    (write_data),
		.key_code      (key_code),
		.read_data     (read_data),
		.wait_ms       (wait_ms),
		.frame_waiting (frame_waiting)
	);

	// An accepted transaction blocks the next one while it executes
	`FPCIO_ASSERT_NXT(a_accept_then_busy, in_valid && !in_stall, in_stall)
	// Load the result register only when it is free
	`FPCIO_ASSERT_IMP(a_load_when_free, ctl.apply || ctl.fin, !out_valid || !out_stall)
	// Divider runs straight after it is started
	`FPCIO_ASSERT_NXT(a_div_runs, ctl.div_start, sts.div_busy)
	// Divider is idle whenever a new transaction is taken
	`FPCIO_ASSERT_IMP(a_div_idle_on_accept, ctl.capture, !sts.div_busy)

endmodule

@@ bench/frame_paced_console_io_device_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_paced_console_io_device_core_test
// Self-checking bench for the console core. A behavioural copy of the
// console (key queue, video memory, frame pacing) predicts every result.
// Directed transactions cover the register map edges, the key queue, video
// memory and frame pacing. Random traffic follows, with random gaps on the
// command side and random stalls on the result side.
// ----------------------------------------------------------------------------
module frame_paced_console_io_device_core_test;
	import fpcio_pkg::*;

	// Spare register and command codes that the package leaves unnamed
	localparam logic [7:0] OFF_RANDOM  = 8'd23;
	localparam logic [2:0] CMD_SPARE_A = 3'd5;
	localparam logic [2:0] CMD_SPARE_B = 3'd7;

	// Slowest transaction is the divide path; give the tail some room
	localparam int DRAIN_CYCLES = 64;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 800;
	localparam int QUIET_ITEMS  = 200;

	typedef struct packed {
		logic [7:0]              read_data;
		logic signed [WAIT_W-1:0] wait_ms;
		logic                    frame_waiting;
	} console_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] cmd = CMD_READ;
	logic [7:0] address = '0;
	logic [7:0] write_data = '0;
	logic [7:0] key_code = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] read_data;
	logic signed [WAIT_W-1:0] wait_ms;
	logic frame_waiting;

	// Predicted console state
	logic [7:0]        key_fifo [KEY_DEPTH];
	logic [7:0]        screen_ram [VIDEO_BYTES];
	logic [7:0]        rate_reg;
	logic [IV_W-1:0]   frame_iv;
	logic [CLK_W-1:0]  frame_due;
	logic              draw_wait;
	logic [CLK_W-1:0]  ms_now;

	// Results predicted but not yet seen, oldest first
	console_result_t console_replies [$];

	bit failed = 1'b0;
	bit idle_on = 1'b0;
	int items_sent = 0;
	int cycle_count = 0;
	int stall_left = 0;

	frame_paced_console_io_device_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cmd           (cmd),
		.address       (address),
		.write_data    (write_data),
		.key_code      (key_code),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.read_data     (read_data),
		.wait_ms       (wait_ms),
		.frame_waiting (frame_waiting)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Abandon the run if it hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				console_replies.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// Result-side back-pressure: random-length bursts of stalled cycles
	always @(negedge clk) begin
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 4);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Compare every accepted result against the oldest prediction
	always @(posedge clk) begin : check_results
		console_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (console_replies.size() == 0) begin
				$display("%0t: result with nothing outstanding: read_data %0d wait_ms %0d",
					$time, read_data, wait_ms);
				failed = 1'b1;
			end else begin
				want = console_replies.pop_front();
				if (read_data !== want.read_data) begin
					$display("%0t: read_data expected %0d actual %0d", $time,
						want.read_data, read_data);
					failed = 1'b1;
				end
				if (wait_ms !== want.wait_ms) begin
					$display("%0t: wait_ms expected %0d actual %0d", $time,
						$signed(want.wait_ms), wait_ms);
					failed = 1'b1;
				end
				if (frame_waiting !== want.frame_waiting) begin
					$display("%0t: frame_waiting expected %0d actual %0d", $time,
						want.frame_waiting, frame_waiting);
					failed = 1'b1;
				end
			end
		end
	end

	// Rate write: interval is 4000/rate, and rate zero turns pacing off
	function automatic void apply_rate(input logic [7:0] rate);
		rate_reg = rate;
		if (rate == 0) begin
			frame_iv  = '0;
			frame_due = '0;
		end else begin
			frame_iv  = IV_W'(RATE_NUM / rate);
			frame_due = ms_now + CLK_W'(frame_iv);
		end
	endfunction

	function automatic void reset_console_model();
		for (int i = 0; i < KEY_DEPTH; i++)
			key_fifo[i] = '0;
		for (int i = 0; i < VIDEO_BYTES; i++)
			screen_ram[i] = SPACE;
		ms_now    = '0;
		draw_wait = 1'b0;
		apply_rate(8'(RESET_RATE));
	endfunction

	// Advance the predicted console by one transaction and return its result
	function automatic console_result_t console_step(input logic [2:0] c,
			input logic [7:0] a, input logic [7:0] wd, input logic [7:0] k);
		console_result_t r;
		logic placed;
		logic [63:0] now, iv, nf, skips, gap;
		int wait_v;
		r.read_data = '0;
		wait_v = -1;
		case (c)
			CMD_READ: begin
				if (a == OFF_RATE)
					r.read_data = rate_reg;
				else if (a >= OFF_KEYS && a < OFF_KEYS + KEY_DEPTH)
					r.read_data = key_fifo[a - OFF_KEYS];
				else if (a >= OFF_VIDEO && a < OFF_VIDEO + VIDEO_BYTES)
					r.read_data = screen_ram[a - OFF_VIDEO];
			end
			CMD_WRITE: begin
				if (a == OFF_RATE) begin
					apply_rate(wd);
				end else if (a == OFF_DRAW) begin
					if (frame_iv != 0)
						draw_wait = 1'b1;
				end else if (a == OFF_KEYS) begin
					for (int i = 0; i < KEY_DEPTH - 1; i++)
						key_fifo[i] = key_fifo[i + 1];
					key_fifo[KEY_DEPTH - 1] = '0;
				end else if (a >= OFF_VIDEO && a < OFF_VIDEO + VIDEO_BYTES) begin
					screen_ram[a - OFF_VIDEO] = wd;
				end
			end
			CMD_KEY: begin
				// First empty slot takes the key; a full queue drops it
				placed = 1'b0;
				for (int i = 0; i < KEY_DEPTH; i++) begin
					if (!placed && key_fifo[i] == 0) begin
						key_fifo[i] = k;
						placed = 1'b1;
					end
				end
			end
			CMD_POLL: begin
				now = 64'(ms_now);
				iv  = 64'(frame_iv);
				if (frame_due != 0 && now + SLACK_MS >= 64'(frame_due)) begin
					// Catch the deadline up by whole intervals, at least one
					if (iv != 0) begin
						nf = 64'(frame_due) + iv;
						if (nf < now) begin
							skips = (now - nf + iv - 1) / iv;
							nf = nf + skips * iv;
						end
						frame_due = nf[CLK_W-1:0];
					end
					draw_wait = 1'b0;
					wait_v = 0;
				end
				if (draw_wait && frame_due != 0) begin
					if (64'(frame_due) > now + GUARD_MS) begin
						gap = 64'(frame_due) - now - GUARD_MS;
						wait_v = (gap > WAIT_MAX) ? WAIT_MAX : int'(gap);
					end else begin
						wait_v = 0;
					end
				end
			end
			CMD_TICK: ms_now = ms_now + 1'b1;
			default: ;
		endcase
		r.wait_ms = wait_v[WAIT_W-1:0];
		r.frame_waiting = draw_wait;
		return r;
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// Offer one transaction and predict its result once it is taken.
	// Entered and left on a falling edge; valid stays high between
	// back-to-back transactions.
	task automatic send_cmd(input logic [2:0] c, input logic [7:0] a,
			input logic [7:0] wd, input logic [7:0] k);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= c;
		address    <= a;
		write_data <= wd;
		key_code   <= k;
		do @(posedge clk); while (in_stall);
		console_replies.push_back(console_step(c, a, wd, k));
		items_sent++;
		@(negedge clk);
	endtask

	// Hold off until every outstanding result has been returned
	task automatic drain_results();
		in_valid <= 1'b0;
		while (console_replies.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [7:0] pick_rate();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'($urandom_range(1, 99));
			default: return 8'($urandom_range(100, 255));
		endcase
	endfunction

	function automatic logic [7:0] pick_address();
		case ($urandom_range(0, 5))
			0: return OFF_RATE;
			1: return OFF_DRAW;
			2: return 8'(OFF_KEYS + $urandom_range(0, KEY_DEPTH - 1));
			3, 4: return 8'(OFF_VIDEO + $urandom_range(0, VIDEO_BYTES - 1));
			default: return rand_byte();
		endcase
	endfunction

	task automatic send_tick();
		send_cmd(CMD_TICK, rand_byte(), rand_byte(), rand_byte());
	endtask

	task automatic send_poll();
		send_cmd(CMD_POLL, rand_byte(), rand_byte(), rand_byte());
	endtask

	task automatic send_write(input logic [7:0] a, input logic [7:0] wd);
		send_cmd(CMD_WRITE, a, wd, rand_byte());
	endtask

	task automatic send_read(input logic [7:0] a);
		send_cmd(CMD_READ, a, rand_byte(), rand_byte());
	endtask

	// One unrelated bus, key or clock transaction
	task automatic random_transaction();
		int pick;
		logic [7:0] a;
		pick = $urandom_range(0, 99);
		a = pick_address();
		if (pick < 30)
			send_tick();
		else if (pick < 40)
			send_poll();
		else if (pick < 55)
			send_read(a);
		else if (pick < 70)
			send_write(a, (a == OFF_RATE) ? pick_rate() : rand_byte());
		else if (pick < 85)
			send_cmd(CMD_KEY, rand_byte(), rand_byte(),
				($urandom_range(0, 15) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
		else if (pick < 93)
			send_write(OFF_KEYS, rand_byte());
		else
			send_cmd(3'($urandom_range(0, 7)), rand_byte(), rand_byte(), rand_byte());
	endtask

	// A program's frame loop: set the rate, draw, let time pass, poll.
	// Long tick runs make the deadline fall several intervals behind.
	task automatic pacing_episode();
		send_write(OFF_RATE, pick_rate());
		repeat ($urandom_range(1, 8)) begin
			send_write(OFF_DRAW, rand_byte());
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(20, 60)) send_tick();
			repeat ($urandom_range(1, 4)) begin
				repeat ($urandom_range(0, 8)) send_tick();
				send_poll();
			end
			if ($urandom_range(0, 5) == 0)
				random_transaction();
		end
	endtask

	task automatic mixed_traffic(input int count);
		int stop_at;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 9) < 3)
				pacing_episode();
			else
				random_transaction();
		end
	endtask

	// Register map edges straight after reset
	task automatic test_reset_state();
		send_read(OFF_RATE);
		send_read(8'(OFF_VIDEO + VIDEO_BYTES - 1));
		send_read(8'd0);
		send_read(8'hFF);
		send_poll();
		send_cmd(CMD_SPARE_A, 8'hFF, 8'hFF, 8'hFF);
		send_cmd(CMD_SPARE_B, 8'h00, 8'h00, 8'h00);
	endtask

	// Zero key, fill past full, shift the head out, write a non-head slot
	task automatic test_key_queue();
		send_cmd(CMD_KEY, 8'h00, 8'h00, 8'h00);
		send_cmd(CMD_KEY, 8'h00, 8'h00, 8'hFF);
		repeat (KEY_DEPTH) send_cmd(CMD_KEY, 8'h00, 8'h00, 8'($urandom_range(1, 255)));
		send_read(8'(OFF_KEYS + KEY_DEPTH - 1));
		send_write(OFF_KEYS, 8'h00);
		send_write(8'(OFF_KEYS + 1), 8'hFF);
		send_read(OFF_KEYS);
	endtask

	// Both ends of video memory, one past it, and the random register
	task automatic test_video_memory();
		send_write(OFF_VIDEO, 8'h00);
		send_write(8'(OFF_VIDEO + VIDEO_BYTES - 1), 8'hFF);
		send_write(8'(OFF_VIDEO + VIDEO_BYTES), 8'hAA);
		send_write(OFF_RANDOM, 8'h55);
		send_read(OFF_VIDEO);
		send_read(8'(OFF_VIDEO + VIDEO_BYTES));
		send_read(OFF_RANDOM);
	endtask

	// Fastest and slowest rates, pacing off, and pacing off mid-wait
	task automatic test_frame_pacing();
		send_write(OFF_RATE, 8'd255);
		send_write(OFF_DRAW, 8'h00);
		send_poll();
		repeat (6) send_tick();
		send_poll();
		send_write(OFF_RATE, 8'd0);
		send_write(OFF_DRAW, 8'h00);
		send_poll();
		send_write(OFF_RATE, 8'd1);
		send_write(OFF_DRAW, 8'h00);
		send_poll();
		send_write(OFF_RATE, 8'd0);
		send_poll();
	endtask

	// Random traffic, with one full drain part way through
	task automatic test_random_traffic();
		mixed_traffic(RANDOM_ITEMS / 2);
		drain_results();
		mixed_traffic(RANDOM_ITEMS / 2);
	endtask

	// Back-to-back traffic with neither side idling
	task automatic test_quiet_tail();
		idle_on = 1'b0;
		mixed_traffic(QUIET_ITEMS);
	endtask

	initial begin
		reset_console_model();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		idle_on = 1'b1;

		test_reset_state();
		test_key_queue();
		test_video_memory();
		test_frame_pacing();
		test_random_traffic();
		test_quiet_tail();

		// Let the last results out, then allow for a late stray one
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!failed)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
